// ===== sv/strict_priority_multi_fifo_core_assert.svh =====
// Assertion macros shared by the strict priority queue design.
`ifndef STRICT_PRIORITY_MULTI_FIFO_CORE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SPMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SPMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spmf_pkg.sv =====
// Shared types, constants and codes of the strict priority queue.
package spmf_pkg;

	// Default sizes of the queue store.
	localparam int LEVELS_DEF      = 5;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF = 16;

	// Fixed field widths of the stream items.
	localparam int PRIO_W     = 8;
	localparam int PAYLOAD_W  = 16;
	localparam int STATUS_W   = 3;
	localparam int OUT_PRIO_W = 3;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;

	// Action codes of an input item.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED   = 3'd0,
		ST_BAD_PRIO = 3'd1,
		ST_FULL     = 3'd2,
		ST_POPPED   = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;     // capture the accepted item
		logic exec;     // commit the item to the queue state
		logic fin_pop;  // load the popped entry into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_hit;  // held item is a pop that finds an entry
		logic out_free; // output register can take a result this cycle
	} sts_t;

endpackage

// ===== sv/spmf_ram.sv =====
// Generic memory with one write port and one registered read port.
module spmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/spmf_ctrl.sv =====
// Controller state machine that sequences one queue operation at a time.
module spmf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spmf_pkg::sts_t sts,
	output spmf_pkg::cmd_t cmd
);
	import spmf_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.take    = 1'b0;
		cmd.exec    = 1'b0;
		cmd.fin_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				// Commit only once the result has somewhere to go.
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = sts.pop_hit ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				cmd.fin_pop = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/spmf_dpath.sv =====
// Datapath: level pointers and counts, entry store and output register.
module spmf_dpath #(
	parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
	parameter int HANDLE_BITS = spmf_pkg::HANDLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spmf_pkg::cmd_t                   cmd,
	output spmf_pkg::sts_t                   sts,
	input  logic                             in_action,
	input  logic [spmf_pkg::PRIO_W-1:0]      in_prio,
	input  logic [spmf_pkg::PAYLOAD_W-1:0]   in_payload,
	output logic                             out_valid,
	input  logic                             out_ready,
	output spmf_pkg::status_t                out_status,
	output logic [spmf_pkg::OUT_PRIO_W-1:0]  out_prio,
	output logic [spmf_pkg::PAYLOAD_W-1:0]   out_payload
);
	import spmf_pkg::*;

	localparam int LW    = $clog2(LEVELS);
	localparam int IW    = $clog2(LEVEL_DEPTH);
	localparam int CW    = $clog2(LEVEL_DEPTH + 1);
	localparam int DEPTH = LEVELS * LEVEL_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = (HANDLE_BITS < PAYLOAD_W) ? HANDLE_BITS : PAYLOAD_W;

	// Held item.
	logic                   act_q;
	logic [PRIO_W-1:0]      prio_q;
	logic [HANDLE_BITS-1:0] pay_q;

	// Per-level ring pointers and fill counts.
	logic [IW-1:0] head_q [LEVELS];
	logic [IW-1:0] tail_q [LEVELS];
	logic [CW-1:0] cnt_q  [LEVELS];

	// Output register.
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [OUT_PRIO_W-1:0] out_prio_q;
	logic [PAYLOAD_W-1:0]  out_pay_q;
	logic [LW-1:0]         pop_lv_q;

	logic                   is_pop;
	logic                   prio_ok;
	logic [PRIO_W-1:0]      prio_m1;
	logic [LW-1:0]          push_lv;
	logic                   lvl_full;
	logic                   push_ok;
	logic                   pop_found;
	logic [LW-1:0]          pop_lv;
	status_t                res_status;
	logic                   load_res;
	logic                   ram_we;
	logic                   ram_re;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;
	logic [HANDLE_BITS-1:0] ram_rdata;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
		next_slot = (s == IW'(LEVEL_DEPTH - 1)) ? '0 : s + IW'(1);
	endfunction

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q  <= in_action;
			prio_q <= in_prio;
			pay_q  <= HANDLE_BITS'(in_payload[CB-1:0]);
		end
	end

	// Most urgent non-empty level: lowest index wins.
	always_comb begin
		pop_found = 1'b0;
		pop_lv    = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				pop_found = 1'b1;
				pop_lv    = LW'(i);
			end
		end
	end

	// Push checks and result code.
	assign is_pop   = (act_q == ACT_POP);
	assign prio_ok  = (prio_q >= PRIO_W'(1)) && (prio_q <= PRIO_W'(LEVELS));
	assign prio_m1  = prio_q - PRIO_W'(1);
	assign push_lv  = prio_m1[LW-1:0];
	assign lvl_full = (cnt_q[push_lv] == CW'(LEVEL_DEPTH));
	assign push_ok  = !is_pop && prio_ok && !lvl_full;

	always_comb begin
		if (is_pop) begin
			res_status = pop_found ? ST_POPPED : ST_EMPTY;
		end else if (!prio_ok) begin
			res_status = ST_BAD_PRIO;
		end else if (lvl_full) begin
			res_status = ST_FULL;
		end else begin
			res_status = ST_PUSHED;
		end
	end

	assign sts.pop_hit  = is_pop && pop_found;
	assign sts.out_free = !out_valid_q || out_ready;

	// Store accesses: each level owns a block of LEVEL_DEPTH entries.
	assign ram_we    = cmd.exec && push_ok;
	assign ram_re    = cmd.exec && sts.pop_hit;
	assign ram_waddr = AW'(AW'(push_lv) * AW'(LEVEL_DEPTH) + AW'(tail_q[push_lv]));
	assign ram_raddr = AW'(AW'(pop_lv) * AW'(LEVEL_DEPTH) + AW'(head_q[pop_lv]));

	spmf_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pay_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pointer and count update on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (ram_we && push_lv == LW'(i)) begin
					tail_q[i] <= next_slot(tail_q[i]);
					cnt_q[i]  <= cnt_q[i] + CW'(1);
				end
				if (ram_re && pop_lv == LW'(i)) begin
					head_q[i] <= next_slot(head_q[i]);
					cnt_q[i]  <= cnt_q[i] - CW'(1);
				end
			end
		end
	end

	// Output valid flag.
	assign load_res = cmd.exec && !sts.pop_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res || cmd.fin_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output fields: direct results now, popped entries after the store read.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pop_lv_q <= pop_lv;
		end
		if (load_res) begin
			out_status_q <= res_status;
			out_prio_q   <= '0;
			out_pay_q    <= '0;
		end else if (cmd.fin_pop) begin
			out_status_q <= ST_POPPED;
			out_prio_q   <= OUT_PRIO_W'({1'b0, pop_lv_q} + (LW + 1)'(1));
			out_pay_q    <= PAYLOAD_W'(ram_rdata[CB-1:0]);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_prio    = out_prio_q;
	assign out_payload = out_pay_q;

endmodule

// ===== sv/strict_priority_multi_fifo_core.sv =====
// Strict priority queue: one ring per level, most urgent non-empty level popped first.
// A push, refused push or empty pop is held, then loaded into the output register;
// a pop that finds an entry passes through the registered read of the entry store as well.
// The input takes no new item until the last one has reached the output register,
// and it stays closed longer while the output stalls.
// Reset (arst_n low) empties every level at once; the entry store itself is not cleared.
`include "strict_priority_multi_fifo_core_assert.svh"

module strict_priority_multi_fifo_core #(
	parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
	parameter int HANDLE_BITS = spmf_pkg::HANDLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// priority_req [7:0], payload [23:8]
	input  logic [spmf_pkg::S_TDATA_W-1:0] s_tdata,
	// action [0]
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_priority [2:0], out_payload [18:3], zeros [23:19]
	output logic [spmf_pkg::M_TDATA_W-1:0] m_tdata,
	// status [2:0]
	output logic [spmf_pkg::STATUS_W-1:0]  m_tuser
);
	import spmf_pkg::*;

	localparam int M_PAD_W = M_TDATA_W - OUT_PRIO_W - PAYLOAD_W;

	cmd_t                  cmd;
	sts_t                  sts;
	status_t               out_status;
	logic [OUT_PRIO_W-1:0] out_prio;
	logic [PAYLOAD_W-1:0]  out_payload;

	// Controller.
	spmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	spmf_dpath #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_action   (s_tuser[0]),
		.in_prio     (s_tdata[PRIO_W-1:0]),
		.in_payload  (s_tdata[PRIO_W+PAYLOAD_W-1:PRIO_W]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_prio    (out_prio),
		.out_payload (out_payload)
	);

	// Pack the result transfer.
	assign m_tdata = {{M_PAD_W{1'b0}}, out_payload, out_prio};
	assign m_tuser = out_status;

	// An accepted item keeps the input closed while it is processed.
	`SPMF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input open after transfer")
	// The popped entry is loaded only right after a committed pop that found one.
	`SPMF_ASSERT_NOW(a_fin_after_pop, cmd.fin_pop, $past(cmd.exec && sts.pop_hit), "stray pop finish")
	// No result is ever loaded over one still waiting.
	`SPMF_ASSERT_NOW(a_no_overwrite, (cmd.exec && !sts.pop_hit) || cmd.fin_pop, sts.out_free, "result overwritten")

endmodule

// ===== sim/strict_priority_multi_fifo_core_test.sv =====
// Self-checking stream testbench for the strict priority multi-level queue core.
`timescale 1ns / 100ps

module strict_priority_multi_fifo_core_test;
	import spmf_pkg::*;

	localparam int LEVELS      = LEVELS_DEF;
	localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEF;
	localparam int HANDLE_BITS = HANDLE_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENTS    = 18;
	localparam int SEG_ITEMS   = 100;
	localparam int DIR_ROWS    = 19;

	// One expected or observed result of the queue.
	typedef struct packed {
		status_t                 status;
		logic [OUT_PRIO_W-1:0]   prio;
		logic [PAYLOAD_W-1:0]    payload;
	} queue_result_t;

	// One line of the directed stimulus; the payload counts up over the repeats.
	// Fixed lines carry their status by hand, and their output fields are zero.
	typedef struct packed {
		logic                    act;
		logic [PRIO_W-1:0]       prio;
		logic [PAYLOAD_W-1:0]    payload;
		logic [5:0]              reps;
		logic                    fixed;
		status_t                 status;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [0:0]            s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	// Shadow copy of the queue contents, one ring per level.
	logic [HANDLE_BITS-1:0] ring_mem [LEVELS][LEVEL_DEPTH];
	int                     rd_ptr [LEVELS];
	int                     wr_ptr [LEVELS];
	int                     fill [LEVELS];

	queue_result_t pending_results [$];
	int            fail_count = 0;
	int unsigned   cycle_count = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;

	strict_priority_multi_fifo_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("simulation failed");
		$finish;
	end

	// Applies one item to the shadow queue and returns the result it gives.
	function automatic queue_result_t queue_predict(input logic act,
			input logic [PRIO_W-1:0] prio, input logic [PAYLOAD_W-1:0] pay);
		queue_result_t res;
		int lv;
		bit done;
		res.status  = ST_PUSHED;
		res.prio    = '0;
		res.payload = '0;
		done        = 1'b0;
		if (act == ACT_PUSH) begin
			if (prio < 1 || prio > LEVELS) begin
				res.status = ST_BAD_PRIO;
			end else if (fill[prio-1] >= LEVEL_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				lv = prio - 1;
				ring_mem[lv][wr_ptr[lv]] = pay[HANDLE_BITS-1:0];
				wr_ptr[lv] = (wr_ptr[lv] + 1) % LEVEL_DEPTH;
				fill[lv]++;
			end
		end else begin
			// Most urgent non-empty level wins.
			res.status = ST_EMPTY;
			for (lv = 0; lv < LEVELS; lv++) begin
				if (!done && fill[lv] != 0) begin
					res.status  = ST_POPPED;
					res.prio    = OUT_PRIO_W'(lv + 1);
					res.payload = PAYLOAD_W'(ring_mem[lv][rd_ptr[lv]]);
					rd_ptr[lv]  = (rd_ptr[lv] + 1) % LEVEL_DEPTH;
					fill[lv]--;
					done        = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Presents one item after a random gap and records its expected result on transfer.
	task automatic send_item(input logic act, input logic [PRIO_W-1:0] prio,
			input logic [PAYLOAD_W-1:0] pay, input bit fixed, input status_t fixed_status);
		int gap;
		queue_result_t res;
		gap = tx_idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pay, prio};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		res = queue_predict(act, prio, pay);
		if (fixed) begin
			res.status  = fixed_status;
			res.prio    = '0;
			res.payload = '0;
		end
		pending_results.push_back(res);
	endtask

	// Result side: random stalls, then each transfer is checked against the oldest expectation.
	initial begin
		int stall;
		queue_result_t want;
		wait (arst_n);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d prio %0d payload %h", $time,
					m_tuser, m_tdata[2:0], m_tdata[18:3]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status || m_tdata[2:0] !== want.prio ||
						m_tdata[18:3] !== want.payload || m_tdata[23:19] !== '0) begin
					$display("%0t: mismatch expected status %0d prio %0d payload %h,",
						$time, want.status, want.prio, want.payload,
						" actual status %0d prio %0d payload %h pad %h",
						m_tuser, m_tdata[2:0], m_tdata[18:3], m_tdata[23:19]);
					fail_count++;
				end
			end
		end
	end

	// Reset, directed stimulus, random stimulus and final report.
	initial begin
		dir_row_t dir_rows [DIR_ROWS];
		int row;
		int rep;
		int seg;
		int idx;
		int pop_pct;
		logic act;
		logic [PRIO_W-1:0] prio;
		logic [PAYLOAD_W-1:0] pay;

		dir_rows = '{
			'{ACT_POP,  8'd0,   16'h0000, 6'd1,  1'b1, ST_EMPTY},    // pop right after reset
			'{ACT_PUSH, 8'd0,   16'hFFFF, 6'd1,  1'b1, ST_BAD_PRIO}, // level below range
			'{ACT_PUSH, 8'd6,   16'h0000, 6'd1,  1'b1, ST_BAD_PRIO}, // level just above range
			'{ACT_PUSH, 8'hFF,  16'h1234, 6'd1,  1'b1, ST_BAD_PRIO}, // largest priority field
			'{ACT_PUSH, 8'd5,   16'hFFFF, 6'd1,  1'b1, ST_PUSHED},
			'{ACT_PUSH, 8'd1,   16'h0000, 6'd1,  1'b1, ST_PUSHED},
			'{ACT_PUSH, 8'd3,   16'hA5A5, 6'd1,  1'b1, ST_PUSHED},
			'{ACT_PUSH, 8'd1,   16'h5A5A, 6'd1,  1'b1, ST_PUSHED},
			'{ACT_POP,  8'hFF,  16'hFFFF, 6'd1,  1'b0, ST_POPPED},   // fields ignored on pop
			'{ACT_POP,  8'd0,   16'h0000, 6'd3,  1'b0, ST_POPPED},
			'{ACT_POP,  8'd0,   16'h0000, 6'd1,  1'b1, ST_EMPTY},
			'{ACT_PUSH, 8'd2,   16'h8000, 6'd16, 1'b1, ST_PUSHED},   // fill one level
			'{ACT_PUSH, 8'd2,   16'hFFFF, 6'd1,  1'b1, ST_FULL},
			'{ACT_PUSH, 8'd4,   16'h0100, 6'd3,  1'b1, ST_PUSHED},
			'{ACT_PUSH, 8'd5,   16'h7FFE, 6'd2,  1'b1, ST_PUSHED},
			'{ACT_POP,  8'd0,   16'h0000, 6'd21, 1'b0, ST_POPPED},   // drain in priority order
			'{ACT_PUSH, 8'd2,   16'h00FF, 6'd2,  1'b1, ST_PUSHED},   // ring pointers wrapped
			'{ACT_POP,  8'd0,   16'h0000, 6'd2,  1'b0, ST_POPPED},
			'{ACT_POP,  8'd0,   16'h0000, 6'd1,  1'b1, ST_EMPTY}
		};

		for (idx = 0; idx < LEVELS; idx++) begin
			rd_ptr[idx] = 0;
			wr_ptr[idx] = 0;
			fill[idx]   = 0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		for (row = 0; row < DIR_ROWS; row++) begin
			for (rep = 0; rep < dir_rows[row].reps; rep++) begin
				send_item(dir_rows[row].act, dir_rows[row].prio,
					dir_rows[row].payload + PAYLOAD_W'(rep), dir_rows[row].fixed,
					dir_rows[row].status);
			end
		end

		// Random part: each segment sets its own share of pops, from mostly filling to mostly draining.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					pop_pct = 10;
				end
				1: begin
					pop_pct = 90;
				end
				default: begin
					pop_pct = 10 + 20 * $urandom_range(0, 4);
				end
			endcase
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (idx = 0; idx < SEG_ITEMS; idx++) begin
				act = ($urandom_range(1, 100) <= pop_pct) ? ACT_POP : ACT_PUSH;
				if ($urandom_range(0, 11) == 0) begin
					prio = PRIO_W'($urandom_range(0, 255));
				end else begin
					prio = PRIO_W'($urandom_range(1, LEVELS));
				end
				pay = PAYLOAD_W'($urandom_range(0, 65535));
				send_item(act, prio, pay, 1'b0, ST_PUSHED);
			end
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding results, then allow for the pipeline latency.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
